// File: rtl/array_list_engine_top_assert.svh
// Assertion macros used by the list engine checker.
`ifndef ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ale_pkg.sv
package ale_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int CNT_OUT_W = 5;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_REMOVE     = 3'd5;
    localparam logic [2:0] OP_DUMP       = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } ale_in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [31:0]   data;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } ale_out_t;

    typedef struct packed {
        logic             capture;
        logic             exec;
        logic [IDX_W-1:0] dump_idx;
    } ale_cmd_t;

    typedef struct packed {
        logic out_free;
        logic dump_more;
    } ale_sts_t;

endpackage

// File: rtl/array_list_engine_top.sv
// Bounded ordered list of up to 16 signed words with clear, front/back push and
// pop, remove-by-value and an in-order dump. One transaction is taken, then
// executed in the following cycle once the result register is free; the input
// stays closed until the last result of the transaction is registered. A dump
// of n entries gives n results, one per cycle unless the result channel stalls.
// Shifts and the key search run across all entries in parallel; back-pressure on
// the result channel stretches the execute cycle. The list contents need no
// clearing after reset: only entries below the fill count are ever read.
module array_list_engine_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ale_pkg::ale_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ale_pkg::ale_out_t m_data
);
    import ale_pkg::*;

    ale_cmd_t cmd;
    ale_sts_t sts;

    ale_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ale_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/ale_ctrl.sv
module ale_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ale_pkg::ale_sts_t sts,
    output ale_pkg::ale_cmd_t cmd
);
    import ale_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.dump_idx = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait for the result register, then run one step
                if (sts.out_free) begin
                    cmd.exec = 1'b1;
                    if (sts.dump_more) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end else begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: rtl/ale_datapath.sv
module ale_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ale_pkg::ale_in_t  s_data,
    input  ale_pkg::ale_cmd_t cmd,
    output ale_pkg::ale_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output ale_pkg::ale_out_t m_data
);
    import ale_pkg::*;

    logic [2:0]       op_reg;
    logic [31:0]      val_reg;
    logic [31:0]      entries_reg [DEPTH];
    logic [31:0]      entries_next [DEPTH];
    logic [31:0]      shifted [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    ale_out_t         m_data_reg;
    ale_out_t         res;

    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] first_hit;
    logic [IDX_W-1:0] found_idx;
    logic [IDX_W-1:0] rm_pos;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      rd_word;
    logic             empty, full, found_any, dump_last;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign dump_last = ((CNT_W'(cmd.dump_idx) + CNT_W'(1)) == count_reg);

    // compare the key against every live entry, keep the lowest hit
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CNT_W'(i) < count_reg) && (entries_reg[i] == val_reg);
        end
    end

    assign first_hit = match & (~match + DEPTH'(1));
    assign found_any = (match != '0);

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                found_idx = found_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        unique case (op_reg)
            OP_POP_FRONT: rm_pos = '0;
            OP_POP_BACK:  rm_pos = IDX_W'(count_reg - CNT_W'(1));
            default:      rm_pos = found_idx;
        endcase
    end

    assign rd_idx  = (op_reg == OP_DUMP) ? cmd.dump_idx : rm_pos;
    assign rd_word = entries_reg[rd_idx];

    // close the gap left by a removal
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i < DEPTH - 1 && IDX_W'(i) >= rm_pos) begin
                shifted[i] = entries_reg[(i + 1) % DEPTH];
            end else begin
                shifted[i] = entries_reg[i];
            end
        end
    end

    always_comb begin
        entries_next = entries_reg;
        count_next   = count_reg;
        res          = '0;
        res.status   = ST_OK;
        res.last     = 1'b1;
        unique case (op_reg)
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 1; i < DEPTH; i++) begin
                        entries_next[i] = entries_reg[i-1];
                    end
                    entries_next[0] = val_reg;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    entries_next[IDX_W'(count_reg)] = val_reg;
                    count_next   = count_reg + CNT_W'(1);
                    res.position = POS_W'(count_reg);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    entries_next = shifted;
                    count_next   = count_reg - CNT_W'(1);
                    res.data     = rd_word;
                    res.position = POS_W'(rm_pos);
                end
            end
            OP_REMOVE: begin
                if (found_any) begin
                    entries_next = shifted;
                    count_next   = count_reg - CNT_W'(1);
                    res.data     = rd_word;
                    res.position = POS_W'(rm_pos);
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            OP_DUMP: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data     = rd_word;
                    res.position = POS_W'(cmd.dump_idx);
                    res.last     = dump_last;
                end
            end
            default: begin
            end
        endcase
        res.count = CNT_OUT_W'(count_next);
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.dump_more = (op_reg == OP_DUMP) && !empty && !dump_last;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_data.operation;
            val_reg <= s_data.value;
        end
        if (cmd.exec) begin
            entries_reg <= entries_next;
            m_data_reg  <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/ale_checker.sv
`include "array_list_engine_top_assert.svh"

module ale_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ale_pkg::ale_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ale_pkg::ale_out_t m_data
);
    import ale_pkg::*;

    logic [CNT_W:0] depth_w;
    assign depth_w = (CNT_W + 1)'(DEPTH);

    // a stalled result holds
    `ALE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // the reported count never exceeds capacity
    `ALE_ASSERT_NOW(a_count_range, m_valid, {1'b0, m_data.count} <= depth_w, "count above capacity")

    // error results are single, zero-data and at position zero
    `ALE_ASSERT_NOW(a_err_shape, m_valid && m_data.status != ST_OK, m_data.last && m_data.data == 0 && m_data.position == 0, "malformed error result")

    // one transaction at a time: input closes right after a take
    `ALE_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input open during execute")

endmodule

bind array_list_engine_top ale_checker u_ale_checker (.*);
